FILE: rtl/core/bbtc_pkg.sv
// ----------------------------------------------------------------------------
// bbtc_pkg
// Shared types and constants for the byte block transposition cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package bbtc_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned IDX_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [BYTE_W-1:0] HEADER_LEN_RST = 8'd54;

  // register indices on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN = 1'd1;

  // byte i of a block lands at position PERM_TABLE[i]
  localparam logic [IDX_W-1:0] PERM_TABLE [BLOCK_BYTES] = '{
    4'd2, 4'd15, 4'd3, 4'd14, 4'd1, 4'd13, 4'd10, 4'd4,
    4'd6, 4'd0,  4'd5, 4'd8,  4'd11, 4'd7, 4'd12, 4'd9
  };

  // controller -> datapath
  typedef struct packed {
    logic take;     // input beat accepted this cycle
    logic permute;  // build cipher block from the gathered bytes
    logic shift;    // cipher byte delivered, advance the output shifter
  } bbtc_cmd_t;

  // datapath -> controller, valid for the byte on the input channel
  typedef struct packed {
    logic hdr_byte;  // byte passes through in clear
    logic blk_done;  // byte completes a block
  } bbtc_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/bbtc_if.sv
// ----------------------------------------------------------------------------
// bbtc_if
// Valid/ready channels for stream bytes in and result bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

interface bbtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       from_header;
  logic       run_last;

  modport source (output valid, output out_byte, output from_header, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input from_header, input run_last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bbtc_datapath.sv
// ----------------------------------------------------------------------------
// bbtc_datapath
// Config registers, header/fill counters, block buffer, chain block and the
// output shifter that holds the result byte(s).
// ----------------------------------------------------------------------------
`default_nettype none

module bbtc_datapath
  import bbtc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [BYTE_W-1:0]    cfg_wdata_i,
  input  wire logic [BYTE_W-1:0]    data_byte_i,
  input  wire logic                 stream_start_i,
  input  wire bbtc_cmd_t            cmd_i,
  output bbtc_sts_t                 sts_o,
  output logic [BYTE_W-1:0]         out_byte_o
);

  logic              chain_mode_q;
  logic [BYTE_W-1:0] hdr_len_q;
  logic [BYTE_W-1:0] hdr_cnt_q;
  logic [IDX_W-1:0]  fill_q;
  logic [BYTE_W-1:0] chain_q  [BLOCK_BYTES];
  logic [BYTE_W-1:0] plain_q  [BLOCK_BYTES];
  logic [BYTE_W-1:0] shift_q  [BLOCK_BYTES];
  logic [BYTE_W-1:0] cipher_d [BLOCK_BYTES];

  logic [BYTE_W-1:0] hdr_cnt_eff;
  logic [IDX_W-1:0]  fill_eff;

  // a stream start restarts counting before the byte is looked at
  assign hdr_cnt_eff = stream_start_i ? '0 : hdr_cnt_q;
  assign fill_eff    = stream_start_i ? '0 : fill_q;

  assign sts_o.hdr_byte = hdr_cnt_eff < hdr_len_q;
  assign sts_o.blk_done = fill_eff == IDX_W'(BLOCK_BYTES - 1);

  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      cipher_d[PERM_TABLE[i]] = plain_q[i] ^ (chain_mode_q ? chain_q[i] : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_mode_q <= 1'b0;
      hdr_len_q    <= HEADER_LEN_RST;
      hdr_cnt_q    <= '0;
      fill_q       <= '0;
      for (int i = 0; i < BLOCK_BYTES; i++) chain_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CHAIN_MODE: chain_mode_q <= cfg_wdata_i[0];
          CFG_HEADER_LEN: hdr_len_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        if (stream_start_i) begin
          for (int i = 0; i < BLOCK_BYTES; i++) chain_q[i] <= '0;
        end
        if (sts_o.hdr_byte) begin
          hdr_cnt_q <= hdr_cnt_eff + 8'd1;
          fill_q    <= fill_eff;
        end else begin
          hdr_cnt_q <= hdr_cnt_eff;
          fill_q    <= fill_eff + IDX_W'(1);  // wraps to zero on a full block
        end
      end
      if (cmd_i.permute) begin
        for (int i = 0; i < BLOCK_BYTES; i++) chain_q[i] <= cipher_d[i];
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      if (sts_o.hdr_byte) begin
        shift_q[0] <= data_byte_i;
      end else begin
        plain_q[fill_eff] <= data_byte_i;
      end
    end
    if (cmd_i.permute) begin
      for (int i = 0; i < BLOCK_BYTES; i++) shift_q[i] <= cipher_d[i];
    end else if (cmd_i.shift) begin
      for (int i = 0; i < BLOCK_BYTES - 1; i++) shift_q[i] <= shift_q[i+1];
    end
  end

  assign out_byte_o = shift_q[0];

endmodule

`default_nettype wire

FILE: rtl/core/bbtc_ctrl.sv
// ----------------------------------------------------------------------------
// bbtc_ctrl
// Sequencer: takes a byte, then delivers a header beat, nothing for a partial
// block, or on a full block permutes and delivers sixteen cipher beats.
// ----------------------------------------------------------------------------
`default_nettype none

module bbtc_ctrl
  import bbtc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic           from_header_o,
  output logic           run_last_o,
  input  wire bbtc_sts_t sts_i,
  output bbtc_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_PERM,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] cnt_q;
  logic             in_beat;
  logic             out_beat;

  assign in_ready_o    = state_q == ST_IDLE;
  assign out_valid_o   = (state_q == ST_HDR) || (state_q == ST_EMIT);
  assign from_header_o = state_q == ST_HDR;
  assign run_last_o    = (state_q == ST_HDR) || (cnt_q == IDX_W'(BLOCK_BYTES - 1));

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  assign cmd_o.take    = in_beat;
  assign cmd_o.permute = state_q == ST_PERM;
  assign cmd_o.shift   = out_beat && (state_q == ST_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            if (sts_i.hdr_byte)      state_q <= ST_HDR;
            else if (sts_i.blk_done) state_q <= ST_PERM;
          end
        end
        ST_HDR: begin
          if (out_beat) state_q <= ST_IDLE;
        end
        ST_PERM: begin
          cnt_q   <= '0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_beat) begin
            cnt_q <= cnt_q + IDX_W'(1);
            if (cnt_q == IDX_W'(BLOCK_BYTES - 1)) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_emit_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PERM) |=> (state_q == ST_EMIT && cnt_q == '0))
    else $error("cipher run does not start at byte zero");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && run_last_o) |=> in_ready_o)
    else $error("input not reopened after final beat");

  a_cipher_not_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.shift |-> !from_header_o)
    else $error("shifter advanced on a header beat");

endmodule

`default_nettype wire

FILE: rtl/core/byte_block_transposition_cipher.sv
// ----------------------------------------------------------------------------
// byte_block_transposition_cipher
// Header pass-through plus 16-byte transposition cipher, ECB or CBC.
// ----------------------------------------------------------------------------
// One byte is taken at a time. A header byte is accepted, then delivered as
// one result beat. A cipher byte that does not finish a block is only
// accepted. The byte that finishes a block is accepted, then the whole block
// is permuted and chained in the permute state, then 16 result beats are
// shifted out of a single output register bank; input is held off until the
// last beat is taken. Configuration must be written only while idle; the
// block itself does not enforce this.
`default_nettype none

module byte_block_transposition_cipher
  import bbtc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [BYTE_W-1:0]    cfg_wdata_i,
  bbtc_in_if.sink                   in_i,
  bbtc_out_if.source                out_o
);

  bbtc_cmd_t cmd;
  bbtc_sts_t sts;

  bbtc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .from_header_o (out_o.from_header),
    .run_last_o    (out_o.run_last),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  bbtc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .data_byte_i    (in_i.data_byte),
    .stream_start_i (in_i.stream_start),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_byte_o     (out_o.out_byte)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte block transposition cipher. A tracker
// mirrors the header count, the block fill and the CBC chain. It queues the
// header and cipher beats that each accepted byte produces, and compares
// every delivered beat with the oldest queued one. Random gaps on both
// channels, one long output hold-off, and register writes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import bbtc_pkg::*;
();

  // byte i of a block goes to position SHUFFLE[i]
  localparam logic [3:0] SHUFFLE [16] = '{
    4'd2, 4'd15, 4'd3, 4'd14, 4'd1, 4'd13, 4'd10, 4'd4,
    4'd6, 4'd0,  4'd5, 4'd8,  4'd11, 4'd7, 4'd12, 4'd9
  };

  typedef struct packed {
    logic [7:0] data;
    logic       clear;
    logic       last;
  } cipher_beat_t;

  class cipher_tracker;
    logic         cbc_on;
    logic [7:0]   hdr_len;
    logic [7:0]   hdr_seen;
    int unsigned  fill;
    logic [7:0]   plain [16];
    logic [7:0]   chain [16];
    cipher_beat_t due_q [$];
    int unsigned  fails;

    function new();
      cbc_on   = 1'b0;
      hdr_len  = 8'd54;
      hdr_seen = '0;
      fill     = 0;
      fails    = 0;
      foreach (plain[i]) plain[i] = '0;
      foreach (chain[i]) chain[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
      if (idx == CFG_CHAIN_MODE) begin
        cbc_on = value[0];
      end else if (idx == CFG_HEADER_LEN) begin
        hdr_len = value;
      end
    endfunction

    // work out the beats caused by one accepted byte
    function void note_byte(logic [7:0] b, logic start);
      logic [7:0] cipher [16];
      logic [7:0] v;
      if (start) begin
        hdr_seen = '0;
        fill     = 0;
        foreach (chain[i]) chain[i] = '0;
      end
      if (hdr_seen < hdr_len) begin
        hdr_seen++;
        due_q.push_back('{data: b, clear: 1'b1, last: 1'b1});
        return;
      end
      plain[fill] = b;
      if (fill != 15) begin
        fill++;
        return;
      end
      fill = 0;
      for (int i = 0; i < 16; i++) begin
        v = cbc_on ? (plain[i] ^ chain[i]) : plain[i];
        cipher[SHUFFLE[i]] = v;
      end
      // chain follows every block, ECB included
      for (int i = 0; i < 16; i++) begin
        chain[i] = cipher[i];
        due_q.push_back('{data: cipher[i], clear: 1'b0, last: (i == 15)});
      end
    endfunction

    task report(string what, int unsigned want, int unsigned got);
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
      fails++;
    endtask

    task check_beat(logic [7:0] b, logic clear, logic last);
      cipher_beat_t want;
      if (due_q.size() == 0) begin
        report("unexpected beat, byte", 0, b);
        return;
      end
      want = due_q.pop_front();
      if (b !== want.data)      report("out_byte", want.data, b);
      if (clear !== want.clear) report("from_header", want.clear, clear);
      if (last !== want.last)   report("run_last", want.last, last);
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BYTE_W-1:0]    cfg_wdata_i;

  bbtc_in_if  in_ch ();
  bbtc_out_if out_ch ();

  byte_block_transposition_cipher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  cipher_tracker tracker = new();

  int unsigned tx_idle_pct = 32;
  int unsigned rx_idle_pct = 54;
  int unsigned hold_left   = 0;
  bit          hold_req    = 1'b0;

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_CHAIN_MODE;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.stream_start = 1'b0;
    out_ch.ready       = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off when asked for
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 120;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_ch.valid && in_ch.ready) tracker.note_byte(in_ch.data_byte, in_ch.stream_start);
      if (out_ch.valid && out_ch.ready)
        tracker.check_beat(out_ch.out_byte, out_ch.from_header, out_ch.run_last);
    end
  end

  task send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.stream_start <= start;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // wait until no beat is owed
  task settle();
    in_ch.valid <= 1'b0;
    // let the tracker note the last accepted byte first
    @(posedge clk_i);
    while (tracker.due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task set_config(input logic mode, input logic [7:0] hdr);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CHAIN_MODE;
    cfg_wdata_i <= {7'd0, mode};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HEADER_LEN;
    cfg_wdata_i <= hdr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [7:0] edge_bytes [16];
    logic [7:0] hdr;
    edge_bytes = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                   8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: header bytes, a restart among them
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // no header, CBC from a zero chain: one full block of bit patterns
    set_config(1'b1, 8'd0);
    for (int i = 0; i < 16; i++) send_byte(edge_bytes[i], i == 0);
    settle();

    // longest header
    set_config(1'b0, 8'd255);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    settle();

    // header length lowered below the count mid-stream
    set_config(1'b0, 8'd3);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    settle();
    set_config(1'b0, 8'd1);
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b0);

    // random phases; streams and partial blocks carry over config changes
    for (int seg = 0; seg < 12; seg++) begin
      settle();
      if (seg < 4) begin
        tx_idle_pct = 32;
        rx_idle_pct = 54;
      end else if (seg < 8) begin
        tx_idle_pct = 54;
        rx_idle_pct = 32;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(7))
        0:       hdr = 8'd0;
        1:       hdr = 8'd255;
        2:       hdr = 8'd54;
        default: hdr = 8'($urandom_range(1, 20));
      endcase
      if ($urandom_range(3) == 0) hdr = 8'd0;
      set_config(1'($urandom_range(1)), hdr);
      if (seg == 9) hold_req = 1'b1;
      for (int k = 0; k < 22; k++) begin
        send_byte(8'($urandom_range(255)),
                  (k == 0) ? ($urandom_range(2) == 0) : ($urandom_range(39) == 0));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.due_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (tracker.fails == 0 && tracker.due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/bbtc_pkg.sv
rtl/core/bbtc_if.sv
rtl/core/bbtc_datapath.sv
rtl/core/bbtc_ctrl.sv
rtl/core/byte_block_transposition_cipher.sv
test/testbench.sv
